>>> hdl/rwpw_pkg.sv
// rwpw_pkg: shared constants and codes for the radial window pixel weighting block.
// Holds the fixed-point constants, window type codes and register indexes.
// No dependencies.
package rwpw_pkg;

	localparam int Q_BITS  = 17;  // Q1.16 weight and phase width
	localparam int COS_W   = 18;  // signed Q1.16 cosine
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	localparam logic [16:0] ONE_Q16     = 17'd65536;
	localparam logic [16:0] ALPHA_RESET = 17'd32768;
	localparam logic [14:0] HAM_B       = 15'd30147;
	localparam logic [12:0] HAM_OFFSET  = 13'd5242;
	localparam logic [63:0] PI_Q30      = 64'd3373259426;

	typedef enum logic [2:0] {
		WIN_BARTLETT   = 3'd0,
		WIN_TRIANGULAR = 3'd1,
		WIN_HANN       = 3'd2,
		WIN_HAMMING    = 3'd3,
		WIN_TUKEY      = 3'd4,
		WIN_BLACKMAN   = 3'd5
	} win_type_t;

	localparam logic [2:0] REG_CENTER_X    = 3'd0;
	localparam logic [2:0] REG_CENTER_Y    = 3'd1;
	localparam logic [2:0] REG_RADIUS      = 3'd2;
	localparam logic [2:0] REG_WINDOW_TYPE = 3'd3;
	localparam logic [2:0] REG_ALPHA       = 3'd4;
	localparam logic [2:0] REG_COLOR_MODE  = 3'd5;

endpackage

>>> hdl/rwpw_sqrt.sv
// rwpw_sqrt: pipelined integer square root, one result bit per stage.
// Carries a sideband vector alongside the root. No package dependencies.
module rwpw_sqrt #(
	parameter int COORD_BITS = 12,
	parameter int SIDE_W     = 33
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [2*COORD_BITS+15:0]  in_val,
	input  logic [SIDE_W-1:0]         in_side,
	output logic                      out_valid,
	output logic [COORD_BITS+7:0]     out_root,
	output logic [SIDE_W-1:0]         out_side
);
	localparam int RB = COORD_BITS + 8;
	localparam int VW = 2 * COORD_BITS + 16;

	logic [VW-1:0]     rem_s   [RB];
	logic [RB-1:0]     root_s  [RB];
	logic              valid_s [RB];
	logic [SIDE_W-1:0] side_s  [RB];

	logic [VW-1:0]     src_rem  [RB];
	logic [RB-1:0]     src_root [RB];
	logic [SIDE_W-1:0] src_side [RB];
	logic [VW:0]       trial    [RB];
	logic [VW-1:0]     nxt_rem  [RB];
	logic [RB-1:0]     nxt_root [RB];

	always_comb begin
		src_rem[0]  = in_val;
		src_root[0] = '0;
		src_side[0] = in_side;
		for (int j = 1; j < RB; j++) begin
			src_rem[j]  = rem_s[j-1];
			src_root[j] = root_s[j-1];
			src_side[j] = side_s[j-1];
		end
		// try setting bit RB-1-j: (q+2^b)^2 - q^2 = q*2^(b+1) + 2^(2b)
		for (int j = 0; j < RB; j++) begin
			trial[j] = ({1'b0, VW'(src_root[j])} << (RB - j))
				+ ((VW+1)'(1) << (2 * (RB - 1 - j)));
			if ({1'b0, src_rem[j]} >= trial[j]) begin
				nxt_rem[j]  = src_rem[j] - trial[j][VW-1:0];
				nxt_root[j] = src_root[j] | (RB'(1) << (RB - 1 - j));
			end else begin
				nxt_rem[j]  = src_rem[j];
				nxt_root[j] = src_root[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < RB; j++) valid_s[j] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
			for (int j = 1; j < RB; j++) valid_s[j] <= valid_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < RB; j++) begin
				rem_s[j]  <= nxt_rem[j];
				root_s[j] <= nxt_root[j];
				side_s[j] <= src_side[j];
			end
		end
	end

	assign out_valid = valid_s[RB-1];
	assign out_root  = root_s[RB-1];
	assign out_side  = side_s[RB-1];

endmodule

>>> hdl/rwpw_div.sv
// rwpw_div: pipelined restoring divider giving a Q_BITS-bit quotient, one bit per stage.
// Depends on rwpw_pkg for the quotient width.
module rwpw_div
	import rwpw_pkg::*;
#(
	parameter int NW     = 45,
	parameter int DW     = 29,
	parameter int SIDE_W = 34
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NW-1:0]     in_num,
	input  logic [DW-1:0]     in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [Q_BITS-1:0] out_quot,
	output logic [SIDE_W-1:0] out_side
);
	logic [NW-1:0]     rem_s   [Q_BITS];
	logic [DW-1:0]     den_s   [Q_BITS];
	logic [Q_BITS-1:0] quot_s  [Q_BITS];
	logic              valid_s [Q_BITS];
	logic [SIDE_W-1:0] side_s  [Q_BITS];

	logic [NW-1:0]     src_rem  [Q_BITS];
	logic [DW-1:0]     src_den  [Q_BITS];
	logic [Q_BITS-1:0] src_quot [Q_BITS];
	logic [SIDE_W-1:0] src_side [Q_BITS];
	logic [NW-1:0]     shd      [Q_BITS];
	logic [NW-1:0]     nxt_rem  [Q_BITS];
	logic [Q_BITS-1:0] nxt_quot [Q_BITS];

	always_comb begin
		src_rem[0]  = in_num;
		src_den[0]  = in_den;
		src_quot[0] = '0;
		src_side[0] = in_side;
		for (int j = 1; j < Q_BITS; j++) begin
			src_rem[j]  = rem_s[j-1];
			src_den[j]  = den_s[j-1];
			src_quot[j] = quot_s[j-1];
			src_side[j] = side_s[j-1];
		end
		for (int j = 0; j < Q_BITS; j++) begin
			shd[j] = NW'(src_den[j]) << (Q_BITS - 1 - j);
			if (src_rem[j] >= shd[j]) begin
				nxt_rem[j]  = src_rem[j] - shd[j];
				nxt_quot[j] = src_quot[j] | (Q_BITS'(1) << (Q_BITS - 1 - j));
			end else begin
				nxt_rem[j]  = src_rem[j];
				nxt_quot[j] = src_quot[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < Q_BITS; j++) valid_s[j] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
			for (int j = 1; j < Q_BITS; j++) valid_s[j] <= valid_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < Q_BITS; j++) begin
				rem_s[j]  <= nxt_rem[j];
				den_s[j]  <= src_den[j];
				quot_s[j] <= nxt_quot[j];
				side_s[j] <= src_side[j];
			end
		end
	end

	assign out_valid = valid_s[Q_BITS-1];
	assign out_quot  = quot_s[Q_BITS-1];
	assign out_side  = side_s[Q_BITS-1];

endmodule

>>> hdl/rwpw_cos.sv
// rwpw_cos: half-wave cosine table with two registered lookups (k and folded 2k).
// Depends on rwpw_pkg for the cosine width and pi constant.
module rwpw_cos
	import rwpw_pkg::*;
#(
	parameter int COS_TABLE_BITS = 10,
	parameter int SIDE_W         = 51
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [COS_TABLE_BITS:0]  in_idx,
	input  logic [SIDE_W-1:0]        in_side,
	output logic                     out_valid,
	output logic signed [COS_W-1:0]  out_cos,
	output logic signed [COS_W-1:0]  out_cos2,
	output logic [SIDE_W-1:0]        out_side
);
	localparam int COS_N = 1 << COS_TABLE_BITS;

	typedef logic signed [COS_W-1:0] cos_rom_t [COS_N+1];

	// shift-subtract quotient, used only while the table is built
	function automatic longint unsigned quot_u64(longint unsigned num, longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], num[i]};
			if (r >= den) begin
				r = r - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Taylor series in Q30 on the quarter wave, rounded to Q16
	function automatic cos_rom_t build_rom();
		cos_rom_t           t;
		logic               neg;
		longint unsigned    m;
		longint unsigned    x;
		longint unsigned    x2;
		longint unsigned    term;
		longint             sum;
		longint             v;
		for (int k = 0; k <= COS_N; k++) begin
			neg  = (2 * k) > COS_N;
			m    = neg ? longint'(COS_N - k) : longint'(k);
			x    = (PI_Q30 * m) >> COS_TABLE_BITS;
			x2   = (x * x) >> 30;
			term = 64'd1 << 30;
			sum  = longint'(term);
			for (int n = 1; n <= 9; n++) begin
				term = quot_u64((term * x2) >> 30, longint'((2 * n - 1) * (2 * n)));
				if ((n & 1) != 0) sum = sum - longint'(term);
				else sum = sum + longint'(term);
			end
			if (sum < 0) sum = 0;
			v = (sum + 8192) >>> 14;
			if (v > 65536) v = 65536;
			t[k] = COS_W'(neg ? -v : v);
		end
		return t;
	endfunction

	localparam cos_rom_t COS_ROM = build_rom();

	logic [COS_TABLE_BITS+1:0] idx2;
	logic [COS_TABLE_BITS:0]   idx2_fold;

	// fold 2k about the table end
	always_comb begin
		idx2 = {in_idx, 1'b0};
		if (idx2 > (COS_TABLE_BITS+2)'(COS_N))
			idx2_fold = (COS_TABLE_BITS+1)'((COS_TABLE_BITS+2)'(2 * COS_N) - idx2);
		else
			idx2_fold = idx2[COS_TABLE_BITS:0];
	end

	logic                    valid_s1;
	logic signed [COS_W-1:0] cos_s1;
	logic signed [COS_W-1:0] cos2_s1;
	logic [SIDE_W-1:0]       side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (en) valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s1  <= COS_ROM[in_idx];
			cos2_s1 <= COS_ROM[idx2_fold];
			side_s1 <= in_side;
		end
	end

	assign out_valid = valid_s1;
	assign out_cos   = cos_s1;
	assign out_cos2  = cos2_s1;
	assign out_side  = side_s1;

endmodule

>>> hdl/radial_window_pixel_weighting_top.sv
// radial_window_pixel_weighting_top: radial window weighting of a pixel stream.
// Pipeline: 3 front stages, COORD_BITS+8 square-root stages, 1 divider setup stage,
// 17 divider stages, 1 cosine table read and 3 weight/pixel stages.
// Throughput: one pixel per cycle; a held output beat freezes the whole pipeline.
// Reset: arst_n clears valid bits and config registers (alpha to 0.5); payload is not reset.
// Depends on rwpw_pkg, rwpw_sqrt, rwpw_div and rwpw_cos.
module radial_window_pixel_weighting_top
	import rwpw_pkg::*;
#(
	parameter int COORD_BITS     = 12,
	parameter int COS_TABLE_BITS = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	// config port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// pixel input
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [11:0]       col,
	input  logic [11:0]       row,
	input  logic [31:0]       pixel_in,
	// pixel output
	output logic              out_valid,
	input  logic              out_stall,
	output logic [31:0]       pixel_out,
	output logic [16:0]       weight
);
	localparam int C   = COORD_BITS;
	localparam int B   = COS_TABLE_BITS;
	localparam int RB  = C + 8;        // root width, distance in Q8
	localparam int VW  = 2 * C + 16;   // radicand width
	localparam int DW  = C + 17;       // divisor width (radius*alpha)
	localparam int NW  = C + 33;       // dividend width (tukey numerator)
	localparam int SQ_SIDE  = 33;      // inside, pixel
	localparam int DIV_SIDE = 34;      // flat, inside, pixel
	localparam int COS_SIDE = 34 + Q_BITS;

	//------------------------------------------------------------------
	// Configuration registers
	//------------------------------------------------------------------
	logic [11:0] center_x_q;
	logic [11:0] center_y_q;
	logic [11:0] radius_q;
	logic [2:0]  window_type_q;
	logic [16:0] alpha_q;
	logic        color_mode_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q    <= '0;
			center_y_q    <= '0;
			radius_q      <= '0;
			window_type_q <= '0;
			alpha_q       <= ALPHA_RESET;
			color_mode_q  <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_CENTER_X:    center_x_q    <= pwdata[11:0];
				REG_CENTER_Y:    center_y_q    <= pwdata[11:0];
				REG_RADIUS:      radius_q      <= pwdata[11:0];
				REG_WINDOW_TYPE: window_type_q <= pwdata[2:0];
				REG_ALPHA:       alpha_q       <= pwdata[16:0];
				REG_COLOR_MODE:  color_mode_q  <= pwdata[0];
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_CENTER_X:    prdata = DATA_W'(center_x_q);
			REG_CENTER_Y:    prdata = DATA_W'(center_y_q);
			REG_RADIUS:      prdata = DATA_W'(radius_q);
			REG_WINDOW_TYPE: prdata = DATA_W'(window_type_q);
			REG_ALPHA:       prdata = DATA_W'(alpha_q);
			REG_COLOR_MODE:  prdata = DATA_W'(color_mode_q);
			default:         prdata = '0;
		endcase
	end

	// Derived config: only the low COORD_BITS of the coordinates count,
	// and alpha saturates at 1.0.
	logic [C-1:0]   cx;
	logic [C-1:0]   cy;
	logic [C-1:0]   rad;
	logic [16:0]    al;
	logic [2*C-1:0] rad_sq_ext;
	logic [DW-1:0]  rad_dw;
	logic [2*C-1:0] rsq_q;   // radius squared
	logic [DW-1:0]  flat_q;  // tukey flat span radius*(1-alpha) in Q16
	logic [DW-1:0]  den_q;   // tukey taper span radius*alpha in Q16

	assign cx         = C'(center_x_q);
	assign cy         = C'(center_y_q);
	assign rad        = C'(radius_q);
	assign al         = (alpha_q > ONE_Q16) ? ONE_Q16 : alpha_q;
	assign rad_sq_ext = (2*C)'(rad);
	assign rad_dw     = DW'(rad);

	// Recompute config products every cycle; user moves config only while idle (unchecked).
	always_ff @(posedge clk) begin
		rsq_q  <= rad_sq_ext * rad_sq_ext;
		flat_q <= rad_dw * DW'(ONE_Q16 - al);
		den_q  <= rad_dw * DW'(al);
	end

	//------------------------------------------------------------------
	// Pipeline enable: advance everything unless the output beat is held.
	//------------------------------------------------------------------
	logic en;
	logic valid_s7;

	assign en        = !(valid_s7 && out_stall);
	assign in_stall  = !en;

	//------------------------------------------------------------------
	// S1: offsets from the center
	//------------------------------------------------------------------
	logic                valid_s1;
	logic signed [C:0]   dx_s1;
	logic signed [C:0]   dy_s1;
	logic [31:0]         pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (en) valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= $signed({1'b0, C'(col)}) - $signed({1'b0, cx});
			dy_s1  <= $signed({1'b0, C'(row)}) - $signed({1'b0, cy});
			pix_s1 <= pixel_in;
		end
	end

	//------------------------------------------------------------------
	// S2: squares and the half-open square test
	//------------------------------------------------------------------
	logic                  valid_s2;
	logic [2*C-1:0]        sqx_s2;
	logic [2*C-1:0]        sqy_s2;
	logic                  insq_s2;
	logic [31:0]           pix_s2;
	logic signed [2*C+1:0] sqx_full;
	logic signed [2*C+1:0] sqy_full;
	logic signed [C+1:0]   rad_sgn;
	logic signed [C+1:0]   dx_ext;
	logic signed [C+1:0]   dy_ext;
	logic                  insq;

	assign sqx_full = dx_s1 * dx_s1;
	assign sqy_full = dy_s1 * dy_s1;
	assign rad_sgn  = $signed({2'b00, rad});
	assign dx_ext   = (C+2)'(dx_s1);
	assign dy_ext   = (C+2)'(dy_s1);
	assign insq     = (dx_ext >= -rad_sgn) && (dx_ext < rad_sgn)
		&& (dy_ext >= -rad_sgn) && (dy_ext < rad_sgn);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (en) valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2  <= sqx_full[2*C-1:0];
			sqy_s2  <= sqy_full[2*C-1:0];
			insq_s2 <= insq;
			pix_s2  <= pix_s1;
		end
	end

	//------------------------------------------------------------------
	// S3: squared distance, circle test, radicand in Q16
	//------------------------------------------------------------------
	logic           valid_s3;
	logic [VW-1:0]  rad_val_s3;
	logic [SQ_SIDE-1:0] sq_side_s3;
	logic [2*C:0]   dist_sq;
	logic           in_circle;

	assign dist_sq   = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign in_circle = insq_s2 && (dist_sq <= {1'b0, rsq_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else if (en) valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// outside pixels feed zero; their weight is forced to zero later
			rad_val_s3 <= in_circle ? {dist_sq[2*C-1:0], 16'd0} : '0;
			sq_side_s3 <= {in_circle, pix_s2};
		end
	end

	//------------------------------------------------------------------
	// Square root: distance in Q8
	//------------------------------------------------------------------
	logic               sq_valid;
	logic [RB-1:0]      dist_q8;
	logic [SQ_SIDE-1:0] sq_side;

	rwpw_sqrt #(
		.COORD_BITS (C),
		.SIDE_W     (SQ_SIDE)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s3),
		.in_val    (rad_val_s3),
		.in_side   (sq_side_s3),
		.out_valid (sq_valid),
		.out_root  (dist_q8),
		.out_side  (sq_side)
	);

	//------------------------------------------------------------------
	// S4: pick dividend and divisor for the window type
	//   bartlett and cosine windows: d*65536 / r
	//   triangular: d*131072 / (2r+1), tukey: (d - flat)*65536 / (r*alpha)
	//------------------------------------------------------------------
	logic                valid_s4;
	logic [NW-1:0]       num_s4;
	logic [DW-1:0]       dvs_s4;
	logic [DIV_SIDE-1:0] div_side_s4;
	logic [C+15:0]       dist_q16;
	logic [DW-1:0]       dist_dw;
	logic [DW-1:0]       taper;
	logic                flat;
	logic [NW-1:0]       num;
	logic [DW-1:0]       dvs;

	assign dist_q16 = {dist_q8, 8'd0};
	assign dist_dw  = DW'(dist_q16);
	assign taper    = dist_dw - flat_q;
	assign flat     = (dist_dw <= flat_q) || (den_q == '0);

	always_comb begin
		case (window_type_q)
			WIN_TRIANGULAR: begin
				num = NW'({dist_q8, 9'd0});
				dvs = DW'({rad, 1'b1});
			end
			WIN_TUKEY: begin
				num = flat ? '0 : {taper, 16'd0};
				dvs = flat ? DW'(1) : den_q;
			end
			default: begin
				num = NW'(dist_q16);
				dvs = rad_dw;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s4 <= 1'b0;
		else if (en) valid_s4 <= sq_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4      <= num;
			dvs_s4      <= dvs;
			div_side_s4 <= {flat, sq_side};
		end
	end

	//------------------------------------------------------------------
	// Divider: phase in Q1.16
	//------------------------------------------------------------------
	logic                div_valid;
	logic [Q_BITS-1:0]   quot;
	logic [DIV_SIDE-1:0] div_side;
	logic [Q_BITS-1:0]   phase;

	rwpw_div #(
		.NW     (NW),
		.DW     (DW),
		.SIDE_W (DIV_SIDE)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s4),
		.in_num    (num_s4),
		.in_den    (dvs_s4),
		.in_side   (div_side_s4),
		.out_valid (div_valid),
		.out_quot  (quot),
		.out_side  (div_side)
	);

	assign phase = (quot > ONE_Q16) ? ONE_Q16 : quot;

	//------------------------------------------------------------------
	// Cosine lookup at k and 2k
	//------------------------------------------------------------------
	logic                    cos_valid;
	logic signed [COS_W-1:0] cos_k;
	logic signed [COS_W-1:0] cos_2k;
	logic [COS_SIDE-1:0]     cos_side;

	rwpw_cos #(
		.COS_TABLE_BITS (B),
		.SIDE_W         (COS_SIDE)
	) u_cos (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.in_idx    (phase[16:16-B]),
		.in_side   ({phase, div_side}),
		.out_valid (cos_valid),
		.out_cos   (cos_k),
		.out_cos2  (cos_2k),
		.out_side  (cos_side)
	);

	//------------------------------------------------------------------
	// S5: hamming and blackman products
	//------------------------------------------------------------------
	logic                    valid_s5;
	logic [17:0]             tsum_s5;   // 1 + cos(k) in Q16, 0..2.0
	logic signed [COS_W-1:0] cos_s5;
	logic [32:0]             ham_s5;
	logic [34:0]             blk_s5;
	logic [Q_BITS-1:0]       phase_s5;
	logic                    flat_s5;
	logic                    inside_s5;
	logic [31:0]             pix_s5;
	logic signed [18:0]      tsum_w;
	logic signed [18:0]      tsum2_w;

	assign tsum_w  = cos_k + 19'sd65536;
	assign tsum2_w = cos_2k + 19'sd65536;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s5 <= 1'b0;
		else if (en) valid_s5 <= cos_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tsum_s5   <= tsum_w[17:0];
			cos_s5    <= cos_k;
			ham_s5    <= HAM_B * tsum_w[17:0];
			blk_s5    <= al * tsum2_w[17:0];
			phase_s5  <= cos_side[COS_SIDE-1 -: Q_BITS];
			flat_s5   <= cos_side[33];
			inside_s5 <= cos_side[32];
			pix_s5    <= cos_side[31:0];
		end
	end

	//------------------------------------------------------------------
	// S6: window weight, clamped to [0, 1.0], zero outside the region
	//------------------------------------------------------------------
	logic               valid_s6;
	logic [16:0]        w_s6;
	logic [31:0]        pix_s6;
	logic signed [21:0] wk;
	logic signed [21:0] blk_sum;
	logic signed [21:0] one_w;
	logic signed [21:0] hann_w;

	assign one_w  = 22'sd65536;
	assign hann_w = $signed({5'd0, tsum_s5[17:1]});
	assign blk_sum = one_w - $signed({4'd0, al, 1'b0}) + 22'(cos_s5)
		+ $signed({3'd0, blk_s5[34:16]});

	always_comb begin
		case (window_type_q) inside
			WIN_BARTLETT,
			WIN_TRIANGULAR: wk = one_w - $signed({5'd0, phase_s5});
			WIN_HANN:       wk = hann_w;
			WIN_HAMMING:    wk = $signed({9'd0, HAM_OFFSET}) + $signed({5'd0, ham_s5[32:16]});
			WIN_TUKEY:      wk = flat_s5 ? one_w : hann_w;
			// weight in Q17; negative clamps to zero
			WIN_BLACKMAN:   wk = (blk_sum < 0) ? '0 : (blk_sum >>> 1);
			default:        wk = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s6 <= 1'b0;
		else if (en) valid_s6 <= valid_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!inside_s5 || wk < 0)
				w_s6 <= '0;
			else if (wk > one_w)
				w_s6 <= ONE_Q16;
			else
				w_s6 <= wk[16:0];
			pix_s6 <= pix_s5;
		end
	end

	//------------------------------------------------------------------
	// S7: scale the channels, truncating; this is the output register
	//------------------------------------------------------------------
	logic [31:0] pix_out_s7;
	logic [16:0] w_s7;
	logic [24:0] prod_g;
	logic [24:0] prod_r;
	logic [24:0] prod_gr;
	logic [24:0] prod_b;

	assign prod_g  = pix_s6[7:0]   * w_s6;
	assign prod_r  = pix_s6[31:24] * w_s6;
	assign prod_gr = pix_s6[23:16] * w_s6;
	assign prod_b  = pix_s6[15:8]  * w_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s7 <= 1'b0;
		else if (en) valid_s7 <= valid_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (color_mode_q)
				pix_out_s7 <= {prod_r[23:16], prod_gr[23:16], prod_b[23:16], 8'd0};
			else
				pix_out_s7 <= {24'd0, prod_g[23:16]};
			w_s7 <= w_s6;
		end
	end

	assign out_valid = valid_s7;
	assign pixel_out = pix_out_s7;
	assign weight    = w_s7;

endmodule

>>> tb/tb_radial_window_pixel_weighting_top.sv
// Testbench for radial_window_pixel_weighting_top: drives pixels through the
// stream port and compares every output beat against an in-bench weight predictor or a directed value.
// Depends on rwpw_pkg and the RTL of the block only.
module tb_radial_window_pixel_weighting_top
	import rwpw_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COS_N = 1 << 10;
	localparam int LIMIT = 600000;

	typedef struct packed {
		logic [31:0] pix;
		logic [16:0] w;
	} weighted_t;

	typedef struct {
		logic [11:0] cx, cy, rad;
		logic [2:0]  win;
		logic [16:0] alpha;
		logic        mode;
	} setting_t;

	typedef struct {
		logic [11:0] rad;
		logic [2:0]  win;
		logic [11:0] c, r;
		logic [31:0] pix;
		bit          known;
		logic [31:0] exp_pix;
		logic [16:0] exp_w;
	} vector_t;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0, prdata;
	logic pready;
	logic in_valid = 0, in_stall;
	logic [11:0] col = '0, row = '0;
	logic [31:0] pixel_in = '0;
	logic out_valid, out_stall = 0;
	logic [31:0] pixel_out;
	logic [16:0] weight;

	radial_window_pixel_weighting_top dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// shadow of the block's registers
	logic [11:0] sh_cx = 0, sh_cy = 0, sh_rad = 0;
	logic [2:0]  sh_win = 0;
	logic [16:0] sh_alpha = ALPHA_RESET;
	logic        sh_mode = 0;

	longint cos_q16 [0:COS_N];
	weighted_t expected_q [$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0, stall_pct = 0;
	bit hold_req = 0;

	// Build the cosine table: Taylor series in Q30 on the quarter wave, round to Q16.
	function automatic void build_cos();
		longint unsigned m, x, x2, term;
		longint sum, v;
		bit neg;
		for (int k = 0; k <= COS_N; k++) begin
			neg = (2 * k) > COS_N;
			m = neg ? COS_N - k : k;
			x = (PI_Q30 * m) >> 10;
			x2 = (x * x) >> 30;
			term = 64'd1 << 30;
			sum = term;
			for (int n = 1; n <= 9; n++) begin
				term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
				if (n % 2) sum -= term;
				else sum += term;
			end
			if (sum < 0) sum = 0;
			v = (sum + 8192) >>> 14;
			if (v > 65536) v = 65536;
			cos_q16[k] = neg ? -v : v;
		end
	endfunction

	function automatic longint cos_lookup(longint unsigned k);
		if (k > 2 * COS_N) k = 2 * COS_N;
		if (k > COS_N) k = 2 * COS_N - k;
		return cos_q16[k];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res = 0, b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint raised_cos(longint unsigned ph);
		return (65536 + cos_lookup(ph >> 6)) >>> 1;
	endfunction

	// Weight one pixel under the shadow settings.
	function automatic weighted_t weigh_pixel(logic [11:0] c, logic [11:0] r, logic [31:0] p);
		longint dx, dy, rr, a, w, w17;
		longint unsigned dq, dd, ph, f, den, tp, k;
		weighted_t res;
		dx = longint'(c) - longint'(sh_cx);
		dy = longint'(r) - longint'(sh_cy);
		rr = sh_rad;
		a = (sh_alpha > ONE_Q16) ? 65536 : sh_alpha;
		w = 0;
		res = '0;
		if (dx >= -rr && dx < rr && dy >= -rr && dy < rr && dx*dx + dy*dy <= rr*rr) begin
			dq = int_sqrt(longint'(dx*dx + dy*dy) << 16);
			dd = dq << 8;
			ph = dd / rr;
			k = ph >> 6;
			case (win_type_t'(sh_win))
				WIN_BARTLETT:   w = 65536 - longint'(ph);
				WIN_TRIANGULAR: w = 65536 - longint'((dq * 512) / (2 * rr + 1));
				WIN_HANN:       w = raised_cos(ph);
				WIN_HAMMING:    w = HAM_OFFSET + ((HAM_B * (cos_lookup(k) + 65536)) >>> 16);
				WIN_TUKEY: begin
					f = rr * (65536 - a);
					den = rr * a;
					if (dd <= f || den == 0) begin
						w = 65536;
					end else begin
						tp = ((dd - f) << 16) / den;
						if (tp > 65536) tp = 65536;
						w = raised_cos(tp);
					end
				end
				WIN_BLACKMAN: begin
					w17 = 65536 - 2 * a + cos_lookup(k)
						+ ((a * (cos_lookup(2 * k) + 65536)) >>> 16);
					w = (w17 < 0) ? 0 : (w17 >>> 1);
				end
				default: w = 0;
			endcase
			if (w < 0) w = 0;
			if (w > 65536) w = 65536;
		end
		res.w = w[16:0];
		if (w != 0) begin
			if (!sh_mode) begin
				res.pix = 32'((longint'(p[7:0]) * w) >> 16);
			end else begin
				for (int sh = 8; sh <= 24; sh += 8)
					res.pix[sh +: 8] = 8'((longint'(p[sh +: 8]) * w) >> 16);
			end
		end
		return res;
	endfunction

	// Register write: setup cycle, then access cycle; pready is always high.
	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_CENTER_X:    sh_cx = val[11:0];
			REG_CENTER_Y:    sh_cy = val[11:0];
			REG_RADIUS:      sh_rad = val[11:0];
			REG_WINDOW_TYPE: sh_win = val[2:0];
			REG_ALPHA:       sh_alpha = val[16:0];
			REG_COLOR_MODE:  sh_mode = val[0];
			default: ;
		endcase
	endtask

	// Wait until every expected beat came back, then let the pipeline settle.
	task automatic drain();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		@(negedge clk);
	endtask

	// Offer one pixel beat (called at a falling edge); record its expectation on accept.
	task automatic send_pixel(logic [11:0] c, logic [11:0] r, logic [31:0] p,
			bit known = 0, weighted_t exp_known = '0);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		col <= c; row <= r; pixel_in <= p;
		do @(posedge clk); while (in_stall);
		expected_q.push_back(known ? exp_known : weigh_pixel(c, r, p));
		@(negedge clk);
	endtask

	// Output checker: compare each accepted beat against the oldest expectation.
	always @(posedge clk) begin
		weighted_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("unexpected output beat pixel_out=%h weight=%0d", pixel_out, weight);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (pixel_out !== e.pix) begin
					$error("pixel_out: expected %h, got %h", e.pix, pixel_out);
					errors++;
				end
				if (weight !== e.w) begin
					$error("weight: expected %0d, got %0d", e.w, weight);
					errors++;
				end
			end
		end
	end

	// Receiver: random stalls per phase, plus a long hold-off on request.
	always @(negedge clk) begin
		static int hold_left = 0;
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1;
		end else if (hold_req) begin
			hold_req = 0;
			hold_left = 300;
			out_stall <= 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	vector_t directed [] = '{
		// zero radius after reset: everything blanks
		'{12'd0,  3'd0, 12'd0,    12'd0,    32'hFFFF_FFFF, 1, 32'h0,  17'd0},
		'{12'd0,  3'd0, 12'd4095, 12'd4095, 32'h0000_00FF, 1, 32'h0,  17'd0},
		'{12'd0,  3'd0, 12'd100,  12'd100,  32'h0000_00FF, 1, 32'h0,  17'd0},
		// bartlett: center, square edge, circle edge, corner in and out
		'{12'd10, 3'd0, 12'd100,  12'd100,  32'hFFFF_FFFF, 1, 32'hFF, 17'd65536},
		'{12'd10, 3'd0, 12'd110,  12'd100,  32'h0000_00FF, 1, 32'h0,  17'd0},
		'{12'd10, 3'd0, 12'd90,   12'd100,  32'h0000_00AB, 0, 32'h0,  17'd0},
		'{12'd10, 3'd0, 12'd107,  12'd107,  32'h0000_0080, 0, 32'h0,  17'd0},
		'{12'd10, 3'd0, 12'd108,  12'd108,  32'h0000_00FF, 1, 32'h0,  17'd0},
		'{12'd10, 3'd0, 12'd103,  12'd96,   32'h0000_00FF, 0, 32'h0,  17'd0},
		// every other window: full weight at the center, and one edge pixel
		'{12'd10, 3'd1, 12'd100,  12'd100,  32'h0000_00FF, 1, 32'hFF, 17'd65536},
		'{12'd10, 3'd1, 12'd90,   12'd95,   32'h0000_00FF, 0, 32'h0,  17'd0},
		'{12'd10, 3'd2, 12'd100,  12'd100,  32'h0000_00FF, 1, 32'hFF, 17'd65536},
		'{12'd10, 3'd2, 12'd95,   12'd100,  32'h0000_00FF, 0, 32'h0,  17'd0},
		'{12'd10, 3'd3, 12'd100,  12'd100,  32'h0000_00FF, 1, 32'hFF, 17'd65536},
		'{12'd10, 3'd3, 12'd90,   12'd100,  32'h0000_00FF, 0, 32'h0,  17'd0},
		'{12'd10, 3'd4, 12'd100,  12'd100,  32'h0000_00FF, 1, 32'hFF, 17'd65536},
		'{12'd10, 3'd4, 12'd92,   12'd100,  32'h0000_00FF, 0, 32'h0,  17'd0},
		'{12'd10, 3'd5, 12'd100,  12'd100,  32'h0000_00FF, 1, 32'hFF, 17'd65536},
		'{12'd10, 3'd5, 12'd96,   12'd104,  32'h0000_00FF, 0, 32'h0,  17'd0},
		// unused window codes give zero weight
		'{12'd10, 3'd6, 12'd100,  12'd100,  32'h0000_00FF, 1, 32'h0,  17'd0},
		'{12'd10, 3'd7, 12'd101,  12'd100,  32'h0000_00FF, 1, 32'h0,  17'd0}
	};

	setting_t phases [] = '{
		'{12'd2048, 12'd2048, 12'd10,   3'd0, 17'd32768,  1'b0},
		'{12'd0,    12'd0,    12'd7,    3'd1, 17'd0,      1'b1},
		'{12'd4095, 12'd4095, 12'd4095, 3'd2, 17'd65536,  1'b0},
		'{12'd100,  12'd3000, 12'd1,    3'd3, 17'd131071, 1'b1},
		'{12'd500,  12'd500,  12'd20,   3'd4, 17'd0,      1'b0},
		'{12'd1000, 12'd200,  12'd15,   3'd4, 17'd20000,  1'b1},
		'{12'd3000, 12'd3000, 12'd33,   3'd5, 17'd65536,  1'b0},
		'{12'd50,   12'd60,   12'd25,   3'd5, 17'd0,      1'b1},
		'{12'd700,  12'd800,  12'd5,    3'd6, 17'd1,      1'b0},
		'{12'd9,    12'd9,    12'd12,   3'd7, 17'd40000,  1'b1},
		'{12'd2000, 12'd1000, 12'd4095, 3'd5, 17'd32768,  1'b1},
		'{12'd10,   12'd4090, 12'd3,    3'd4, 17'd65536,  1'b0}
	};

	initial begin
		int off;
		logic [11:0] c, r;
		build_cos();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed table: change radius or window only with the pipeline empty.
		reg_write(REG_CENTER_X, 32'd100);
		reg_write(REG_CENTER_Y, 32'd100);
		foreach (directed[i]) begin
			if (directed[i].rad != sh_rad || directed[i].win != sh_win) begin
				in_valid <= 0;
				drain();
				reg_write(REG_RADIUS, 32'(directed[i].rad));
				reg_write(REG_WINDOW_TYPE, 32'(directed[i].win));
			end
			send_pixel(directed[i].c, directed[i].r, directed[i].pix,
				directed[i].known, {directed[i].exp_pix, directed[i].exp_w});
		end
		in_valid <= 0;

		// Random phases: new settings each time, cycling through the idle patterns.
		foreach (phases[i]) begin
			drain();
			reg_write(REG_CENTER_X, 32'(phases[i].cx));
			reg_write(REG_CENTER_Y, 32'(phases[i].cy));
			reg_write(REG_RADIUS, 32'(phases[i].rad));
			reg_write(REG_WINDOW_TYPE, 32'(phases[i].win));
			reg_write(REG_ALPHA, 32'(phases[i].alpha));
			reg_write(REG_COLOR_MODE, 32'(phases[i].mode));
			case (i % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 80; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 80; end
				default: begin send_idle_pct = 11; stall_pct = 11; end
			endcase
			for (int n = 0; n < 170; n++) begin
				// hold the output long enough to back up into the input
				if (i == 4 && n == 20) hold_req = 1;
				// pause the source until everything has come back
				if (i == 5 && n == 80) begin
					in_valid <= 0;
					drain();
				end
				if ($urandom_range(9) < 8) begin
					// mostly near the window, a pixel or two past its edges
					off = $urandom_range(2 * phases[i].rad + 3);
					c = sh_cx + 12'(off - phases[i].rad - 2);
					off = $urandom_range(2 * phases[i].rad + 3);
					r = sh_cy + 12'(off - phases[i].rad - 2);
				end else begin
					c = $urandom_range(4095);
					r = $urandom_range(4095);
				end
				send_pixel(c, r, $urandom());
			end
			in_valid <= 0;
		end

		send_idle_pct = 0;
		stall_pct = 0;
		drain();
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> radial_window_pixel_weighting_top.f
hdl/rwpw_pkg.sv
hdl/rwpw_sqrt.sv
hdl/rwpw_div.sv
hdl/rwpw_cos.sv
hdl/radial_window_pixel_weighting_top.sv
tb/tb_radial_window_pixel_weighting_top.sv
